FILE: rtl/core/cil_pkg.sv
// cil_pkg: shared constants and types for the compacting indexed list
// holds request kind codes, field widths and the default list depth
// no dependencies
package cil_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_APPEND = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;

  localparam int DEFAULT_DEPTH = 64;
  localparam int DIGIT_W       = 4;
  localparam int POS_W         = 6;
  localparam int OUT_W         = 5;
  localparam int COUNT_W       = 7;
  localparam int ENTRY_W       = 2 * DIGIT_W;

  localparam logic signed [OUT_W-1:0] NEG_ONE = -5'sd1;

endpackage

FILE: rtl/core/cil_store.sv
// cil_store: entry memory of the compacting indexed list
// one write port and one registered read port
// depends on cil_pkg for the entry width and the default depth
module cil_store #(
  parameter int DEPTH = cil_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [cil_pkg::ENTRY_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [cil_pkg::ENTRY_W-1:0]  rdata
);

  logic [cil_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/compacting_indexed_list.sv
// compacting_indexed_list: ordered list with append, indexed read and compacting remove
// top level: request sequencer, entry count and result register
// depends on cil_pkg and cil_store
//
// The block keeps an ordered list of up to DEPTH entries, each a colour digit and a
// value digit, in a single-port-write, single-port-read memory. A request transaction
// appends an entry at the end, reads the entry at an index, or removes the entry at an
// index and moves every later entry down one place. Each request yields exactly one
// result transaction carrying the entry read or removed (zero in both fields for an
// append, -1 in both with error set for an index at or beyond the count or an unused
// kind), an error flag that also marks an append to a full list, and the entry count
// after the operation (low 7 bits). One request is in work at a time and in_stall is
// high until its result has been placed in the output register; a result waiting
// there does not hold back the next request. An append, a bad index or an unused
// kind goes straight to the finish state; a read or remove first passes the fetch
// state, and a remove then shifts each later entry down one place, one entry per
// cycle through the one memory read port and one write port. An entry read that was
// never written cannot happen, so the memory needs no clearing after reset.
module compacting_indexed_list #(
  parameter int DEPTH = cil_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [cil_pkg::DIGIT_W-1:0]         entry_color,
  input  logic [cil_pkg::DIGIT_W-1:0]         entry_value,
  input  logic [cil_pkg::POS_W-1:0]           position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cil_pkg::OUT_W-1:0]    out_color,
  output logic signed [cil_pkg::OUT_W-1:0]    out_value,
  output logic                                error,
  output logic [cil_pkg::COUNT_W-1:0]         count
);

  localparam int IW    = $clog2(DEPTH);          // memory address width
  localparam int CW    = $clog2(DEPTH + 1);      // entry count width, holds DEPTH
  localparam int XW    = CW + 1;                 // headroom for index + 2
  localparam int CMP_W = (XW > cil_pkg::POS_W) ? XW : cil_pkg::POS_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]  state;
  logic [CW-1:0] entry_count;
  logic [IW-1:0] idx;          // index of the entry in work / slot being filled
  logic          op_remove;

  // staged result, moved into the output register once it is free
  logic signed [cil_pkg::OUT_W-1:0] res_color;
  logic signed [cil_pkg::OUT_W-1:0] res_value;
  logic                             res_err;

  // memory ports
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [cil_pkg::ENTRY_W-1:0]   mem_wdata;
  logic [IW-1:0]                 mem_raddr;
  logic [cil_pkg::ENTRY_W-1:0]   mem_rdata;

  // shared index unit: index step and compare against the count
  logic [XW-1:0] idx_plus1;
  logic [XW-1:0] idx_plus2;
  logic [XW-1:0] count_x;
  logic          more_after1;   // an entry exists after idx
  logic          more_after2;   // an entry exists two places after idx

  logic          accept;
  logic          list_full;
  logic          bad_index;
  logic          out_free;
  logic          load_out;
  cil_pkg::kind_t req_kind;

  assign req_kind    = cil_pkg::kind_t'(kind);
  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign load_out    = (state == S_FINISH) && out_free;

  assign count_x     = XW'(entry_count);
  assign idx_plus1   = XW'(idx) + XW'(1);
  assign idx_plus2   = XW'(idx) + XW'(2);
  assign more_after1 = idx_plus1 < count_x;
  assign more_after2 = idx_plus2 < count_x;

  assign list_full   = (entry_count == CW'(DEPTH));
  assign bad_index   = CMP_W'(position) >= CMP_W'(entry_count);

  // write port: append at the end, or shift an entry down during a remove
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    if (state == S_IDLE) begin
      mem_we    = accept && (req_kind == cil_pkg::KIND_APPEND) && !list_full;
      mem_waddr = IW'(entry_count);
      mem_wdata = {entry_color, entry_value};
    end else if (state == S_SHIFT) begin
      mem_we    = 1'b1;
    end
  end

  // read port: the addressed entry first, then the one behind each slot being filled
  always_comb begin
    case (state)
      S_IDLE:  mem_raddr = IW'(position);
      S_FETCH: mem_raddr = IW'(idx_plus1);
      S_SHIFT: mem_raddr = IW'(idx_plus2);
      default: mem_raddr = idx;
    endcase
  end

  cil_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_kind)
              cil_pkg::KIND_APPEND: begin
                if (!list_full) begin
                  entry_count <= entry_count + CW'(1);
                end
                state <= S_FINISH;
              end
              cil_pkg::KIND_REMOVE, cil_pkg::KIND_READ: begin
                if (bad_index) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FETCH: begin
          if (op_remove && more_after1) begin
            state <= S_SHIFT;
          end else begin
            if (op_remove) begin
              entry_count <= entry_count - CW'(1);
            end
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          // one entry moved down per cycle
          if (!more_after2) begin
            entry_count <= entry_count - CW'(1);
            state       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and staged result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx       <= IW'(position);
          op_remove <= (req_kind == cil_pkg::KIND_REMOVE);
          case (req_kind)
            cil_pkg::KIND_APPEND: begin
              res_color <= '0;
              res_value <= '0;
              res_err   <= list_full;
            end
            cil_pkg::KIND_REMOVE, cil_pkg::KIND_READ: begin
              res_color <= cil_pkg::NEG_ONE;
              res_value <= cil_pkg::NEG_ONE;
              res_err   <= bad_index;
            end
            default: begin
              res_color <= cil_pkg::NEG_ONE;
              res_value <= cil_pkg::NEG_ONE;
              res_err   <= 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        // entry at the requested index is now on the read port
        res_color <= {1'b0, mem_rdata[cil_pkg::ENTRY_W-1:cil_pkg::DIGIT_W]};
        res_value <= {1'b0, mem_rdata[cil_pkg::DIGIT_W-1:0]};
        res_err   <= 1'b0;
      end
      S_SHIFT: begin
        idx <= IW'(idx_plus1);
      end
      default: begin
      end
    endcase
  end

  // output register, parts the sequencer from the result consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_color <= res_color;
      out_value <= res_value;
      error     <= res_err;
      count     <= cil_pkg::COUNT_W'(entry_count);
    end
  end

endmodule
